FILE: rtl/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

  // Port widths of the request and result words
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int LAST_W   = 11;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_SET    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDEF = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } sit_state_t;

endpackage

FILE: rtl/sit_ram.sv
`timescale 1ns / 1ps

module sit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sparse_indexed_table_unit.sv
`timescale 1ns / 1ps

// Sparse table of DEPTH entries with a valid bit each, a count of valid
// entries and the highest valid index (-1 when empty). A request word is
// taken when start is high and busy is low; busy then stays high through
// the execute state, and the result word appears on the out_ ports for
// exactly one cycle with out_valid, raised in the same cycle as busy falls,
// so a new request is taken no sooner than its strobe. Removing the
// highest entry, unless it is entry 0, adds a downward scan of the
// valid-bit memory at one index per cycle, which can run to index 0 when
// the table empties; busy stays high through it. After reset the valid-bit
// memory is swept clear, one entry per cycle, with busy high. The receiver
// cannot stall: a result word is lost if it is not taken in its strobe cycle.
module sparse_indexed_table_unit #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sit_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [sit_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [sit_pkg::VALUE_W-1:0]   in_write_value,
  output logic                          out_valid,
  output logic [sit_pkg::STATUS_W-1:0]  out_status,
  output logic [sit_pkg::VALUE_W-1:0]   out_read_value,
  output logic [sit_pkg::INDEX_W-1:0]   out_slot_index,
  output logic [sit_pkg::COUNT_W-1:0]   out_valid_count,
  output logic signed [sit_pkg::LAST_W-1:0] out_last_index
);

  import sit_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [AW:0]   EMPTY     = '1;
  localparam logic signed [AW:0]   TOP_SLOT  = (AW + 1)'(DEPTH - 1);

  sit_state_t state_r, state_nxt;

  // Request registers
  logic [OPCODE_W-1:0]   op_r, op_nxt;
  logic [INDEX_W-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [DATA_WIDTH-1:0] wdata_r, wdata_nxt;

  // Table bookkeeping
  logic [CW-1:0]         count_r, count_nxt;
  logic signed [AW:0]    high_r, high_nxt;

  // Clearing sweep and downward scan
  logic [AW-1:0]         clr_r, clr_nxt;
  logic signed [AW:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]         chk_r, chk_nxt;
  logic                  chk_act_r, chk_act_nxt;

  // Result registers
  logic                  res_valid_r, res_valid_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [VALUE_W-1:0]    rd_r, rd_nxt;
  logic [INDEX_W-1:0]    slot_r, slot_nxt;

  // Memory ports
  logic                  vld_we;
  logic [AW-1:0]         vld_waddr;
  logic                  vld_wdata;
  logic [AW-1:0]         vld_raddr;
  logic                  vld_rdata;
  logic                  ent_we;
  logic [DATA_WIDTH-1:0] ent_rdata;

  // Decision flags
  logic                  accept;
  logic                  is_append;
  logic                  full;
  logic                  beyond;
  logic                  above_high;
  logic                  at_high;
  logic                  go_scan;
  logic                  scan_hit;
  logic                  scan_end;
  logic [63:0]           wide_in;
  logic [63:0]           wide_rd;
  logic signed [AW:0]    addr_s;
  logic signed [AW:0]    append_pos;

  sit_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (vld_raddr),
    .rdata (vld_rdata)
  );

  sit_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (addr_r),
    .wdata (wdata_r),
    .raddr (addr_nxt),
    .rdata (ent_rdata)
  );

  // Decode the request in flight and the scan step
  always_comb begin
    accept     = (state_r == ST_IDLE) && start;
    is_append  = (op_r == OP_APPEND);
    full       = (high_r == TOP_SLOT);
    beyond     = !is_append && (32'(idx_r) >= DEPTH);
    addr_s     = $signed({1'b0, addr_r});
    above_high = addr_s > high_r;
    at_high    = addr_s == high_r;
    append_pos = high_r + (AW + 1)'(1);
    wide_in    = 64'(in_write_value);
    wide_rd    = 64'(ent_rdata);
    go_scan    = (op_r == OP_REMOVE) && !beyond && !above_high && vld_rdata && at_high
                 && (addr_r != '0);
    scan_hit   = chk_act_r && vld_rdata;
    scan_end   = !scan_hit && ptr_r[AW];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = go_scan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    addr_nxt      = ptr_r[AW-1:0];
    wdata_nxt     = wdata_r;
    count_nxt     = count_r;
    high_nxt      = high_r;
    clr_nxt       = clr_r;
    ptr_nxt       = ptr_r;
    chk_nxt       = chk_r;
    chk_act_nxt   = chk_act_r;
    res_valid_nxt = 1'b0;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    slot_nxt      = slot_r;
    vld_we        = 1'b0;
    vld_waddr     = addr_r;
    vld_wdata     = 1'b0;
    ent_we        = 1'b0;

    case (state_r)
      // Sweep the valid bits clear
      ST_CLEAR: begin
        vld_we    = 1'b1;
        vld_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
      end

      // Take the request word and start the reads
      ST_IDLE: begin
        if (in_opcode == OP_APPEND) begin
          addr_nxt = append_pos[AW-1:0];
        end else begin
          addr_nxt = AW'(32'(in_entry_index));
        end
        if (accept) begin
          op_nxt    = in_opcode;
          idx_nxt   = in_entry_index;
          wdata_nxt = wide_in[DATA_WIDTH-1:0];
        end
      end

      // Decide, write back and form the result
      ST_EXEC: begin
        res_valid_nxt = !go_scan;
        rd_nxt        = '0;
        status_nxt    = STAT_OK;
        slot_nxt      = idx_r;
        if (is_append && full) begin
          status_nxt = STAT_RANGE;
          slot_nxt   = '0;
        end else if (beyond) begin
          status_nxt = STAT_RANGE;
        end else if (op_r == OP_SET || is_append) begin
          ent_we = 1'b1;
          if (is_append) begin
            slot_nxt = INDEX_W'(32'(addr_r));
          end
          if (!vld_rdata) begin
            vld_we    = 1'b1;
            vld_wdata = 1'b1;
            count_nxt = count_r + CW'(1);
            if (above_high) begin
              high_nxt = addr_s;
            end
          end
        end else if (above_high || !vld_rdata) begin
          status_nxt = STAT_UNDEF;
        end else begin
          rd_nxt = wide_rd[VALUE_W-1:0];
          if (op_r == OP_REMOVE) begin
            vld_we    = 1'b1;
            count_nxt = count_r - CW'(1);
            if (at_high) begin
              if (addr_r == '0) begin
                high_nxt = EMPTY;
              end else begin
                ptr_nxt     = addr_s - (AW + 1)'(1);
                chk_act_nxt = 1'b0;
              end
            end
          end
        end
      end

      // Walk down one index per cycle until a valid bit shows up or index 0 is passed
      ST_SCAN: begin
        if (scan_hit) begin
          high_nxt      = $signed({1'b0, chk_r});
          res_valid_nxt = 1'b1;
        end else if (scan_end) begin
          high_nxt      = EMPTY;
          res_valid_nxt = 1'b1;
        end else begin
          chk_nxt     = ptr_r[AW-1:0];
          chk_act_nxt = 1'b1;
          ptr_nxt     = ptr_r - (AW + 1)'(1);
        end
      end

      default: ;
    endcase
  end

  assign vld_raddr = addr_nxt;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      count_r     <= '0;
      high_r      <= EMPTY;
      clr_r       <= '0;
      chk_act_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      high_r      <= high_nxt;
      clr_r       <= clr_nxt;
      chk_act_r   <= chk_act_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    ptr_r    <= ptr_nxt;
    chk_r    <= chk_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    slot_r   <= slot_nxt;
  end

  // Drive the ports
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = res_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = rd_r;
  assign out_slot_index  = slot_r;
  assign out_valid_count = COUNT_W'(count_r);
  assign out_last_index  = LAST_W'(high_r);

endmodule
